// ===== sv/bdlmp_pkg.sv =====
// ----------------------------------------------------------------------------
// bdlmp_pkg
// shared widths, register indexes and reset values of the button debouncer
// ----------------------------------------------------------------------------
package bdlmp_pkg;

   localparam int unsigned TickWidth   = 32;
   localparam int unsigned CountWidth  = 4;
   localparam int unsigned TimerWidth  = 16;
   localparam int unsigned CsrWidth    = 16;
   localparam int unsigned CsrIdxWidth = 2;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_DEBOUNCE_SAMPLES   = 2'd0,
      CSR_LONG_PRESS_TICKS   = 2'd1,
      CSR_SEQUENCE_GAP_TICKS = 2'd2,
      CSR_PRESS_COUNT_TARGET = 2'd3
   } csr_index_type;

   localparam logic [CountWidth-1:0] DebounceSamplesReset  = 4'd2;
   localparam logic [TimerWidth-1:0] LongPressTicksReset   = 16'd1200;
   localparam logic [TimerWidth-1:0] SequenceGapTicksReset = 16'd2000;
   localparam logic [CountWidth-1:0] PressCountTargetReset = 4'd6;

endpackage

// ===== sv/bdlmp_req_if.sv =====
// ----------------------------------------------------------------------------
// bdlmp_req_if
// poll item channel: raw button level and tick timestamp
// ----------------------------------------------------------------------------
interface bdlmp_req_if;
   logic                                valid;
   logic                                ready;
   logic                                raw_level;
   logic [bdlmp_pkg::TickWidth-1:0]     now_ticks;

   modport source (output valid, output raw_level, output now_ticks, input ready);
   modport sink   (input valid, input raw_level, input now_ticks, output ready);
endinterface

// ===== sv/bdlmp_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bdlmp_rsp_if
// result item channel: event pulses, stable level and click count
// ----------------------------------------------------------------------------
interface bdlmp_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                long_press_pulse;
   logic                                multi_press_pulse;
   logic                                debounced_level;
   logic [bdlmp_pkg::CountWidth-1:0]    click_count;

   modport source (output valid, output long_press_pulse, output multi_press_pulse,
                   output debounced_level, output click_count, input ready);
   modport sink   (input valid, input long_press_pulse, input multi_press_pulse,
                   input debounced_level, input click_count, output ready);
endinterface

// ===== sv/button_debounce_long_multi_press.sv =====
// ----------------------------------------------------------------------------
// button_debounce_long_multi_press
// debounces polls of an active-low button, flags long presses and multi clicks
// ----------------------------------------------------------------------------
// an accepted item passes through the input register, then the result register
// throughput: one item per cycle while results are taken, as the state updates on each advance
// a held result stalls the input register, which then drops req ready
// reset: synchronous, clears valids, loads default settings, button released,
// click count and timestamps zero
module button_debounce_long_multi_press (
   input  logic                                  clock,
   input  logic                                  reset,
   bdlmp_req_if.sink                             req_chan,
   bdlmp_rsp_if.source                           rsp_chan,
   input  logic                                  csr_write_en,
   input  logic [bdlmp_pkg::CsrIdxWidth-1:0]     csr_index,
   input  logic [bdlmp_pkg::CsrWidth-1:0]        csr_wdata
);

   localparam int unsigned TW = bdlmp_pkg::TickWidth;
   localparam int unsigned CW = bdlmp_pkg::CountWidth;
   localparam int unsigned MW = bdlmp_pkg::TimerWidth;

   // settings
   logic [CW-1:0] debounce_samples_ff;
   logic [MW-1:0] long_press_ticks_ff;
   logic [MW-1:0] sequence_gap_ticks_ff;
   logic [CW-1:0] press_count_target_ff;

   // input register
   logic          in_valid_ff;
   logic          in_level_ff;
   logic [TW-1:0] in_now_ff;

   // button state
   logic          last_sample_ff,  last_sample_in;
   logic          stable_ff,       stable_in;
   logic [CW-1:0] same_run_ff,     same_run_in;
   logic [TW-1:0] press_start_ff,  press_start_in;
   logic [TW-1:0] last_release_ff, last_release_in;
   logic [CW-1:0] tally_ff,        tally_in;
   logic          long_done_ff,    long_done_in;

   // result register
   logic          out_valid_ff;
   logic          out_long_ff,  long_in;
   logic          out_multi_ff, multi_in;
   logic          out_level_ff;
   logic [CW-1:0] out_count_ff;

   logic          advance;
   logic [TW-1:0] since_release;
   logic [TW-1:0] since_press;
   logic          gap_over;
   logic          accept_change;
   logic [CW-1:0] tally_inc;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   assign since_release = in_now_ff - last_release_ff;
   assign since_press   = in_now_ff - press_start_ff;

   always_comb begin
      last_sample_in  = last_sample_ff;
      stable_in       = stable_ff;
      same_run_in     = same_run_ff;
      press_start_in  = press_start_ff;
      last_release_in = last_release_ff;
      tally_in        = tally_ff;
      long_done_in    = long_done_ff;
      long_in         = 1'b0;
      multi_in        = 1'b0;
      tally_inc       = '0;

      gap_over = (tally_ff != '0) && (since_release > {{(TW-MW){1'b0}}, sequence_gap_ticks_ff});
      if (stable_ff && gap_over) begin
         tally_in = '0;
      end

      // sample run
      if (in_level_ff == last_sample_ff) begin
         if (same_run_ff < debounce_samples_ff) begin
            same_run_in = same_run_ff + 1'b1;
         end
      end else begin
         last_sample_in = in_level_ff;
         same_run_in    = {{(CW-1){1'b0}}, 1'b1};
      end

      // long press on the level held before this poll
      if (!stable_ff && !long_done_ff &&
          since_press >= {{(TW-MW){1'b0}}, long_press_ticks_ff}) begin
         long_in      = 1'b1;
         long_done_in = 1'b1;
         tally_in     = '0;
      end

      accept_change = !(same_run_in < debounce_samples_ff || last_sample_in == stable_ff);
      if (accept_change) begin
         stable_in = last_sample_in;
         if (!last_sample_in) begin
            press_start_in = in_now_ff;
            long_done_in   = 1'b0;
         end else if (!long_done_in) begin
            if ((tally_in != '0) &&
                (since_release > {{(TW-MW){1'b0}}, sequence_gap_ticks_ff})) begin
               tally_in = '0;
            end
            last_release_in = in_now_ff;
            tally_inc       = tally_in + 1'b1;
            if (tally_inc >= press_count_target_ff) begin
               multi_in = 1'b1;
               tally_in = '0;
            end else begin
               tally_in = tally_inc;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_samples_ff   <= bdlmp_pkg::DebounceSamplesReset;
         long_press_ticks_ff   <= bdlmp_pkg::LongPressTicksReset;
         sequence_gap_ticks_ff <= bdlmp_pkg::SequenceGapTicksReset;
         press_count_target_ff <= bdlmp_pkg::PressCountTargetReset;
      end else if (csr_write_en) begin
         unique case (bdlmp_pkg::csr_index_type'(csr_index))
            bdlmp_pkg::CSR_DEBOUNCE_SAMPLES:   debounce_samples_ff   <= csr_wdata[CW-1:0];
            bdlmp_pkg::CSR_LONG_PRESS_TICKS:   long_press_ticks_ff   <= csr_wdata[MW-1:0];
            bdlmp_pkg::CSR_SEQUENCE_GAP_TICKS: sequence_gap_ticks_ff <= csr_wdata[MW-1:0];
            bdlmp_pkg::CSR_PRESS_COUNT_TARGET: press_count_target_ff <= csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         last_sample_ff  <= 1'b1;
         stable_ff       <= 1'b1;
         same_run_ff     <= '0;
         press_start_ff  <= '0;
         last_release_ff <= '0;
         tally_ff        <= '0;
         long_done_ff    <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            out_valid_ff    <= 1'b1;
            last_sample_ff  <= last_sample_in;
            stable_ff       <= stable_in;
            same_run_ff     <= same_run_in;
            press_start_ff  <= press_start_in;
            last_release_ff <= last_release_in;
            tally_ff        <= tally_in;
            long_done_ff    <= long_done_in;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_level_ff <= req_chan.raw_level;
         in_now_ff   <= req_chan.now_ticks;
      end
      if (advance) begin
         out_long_ff  <= long_in;
         out_multi_ff <= multi_in;
         out_level_ff <= stable_in;
         out_count_ff <= tally_in;
      end
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.long_press_pulse  = out_long_ff;
   assign rsp_chan.multi_press_pulse = out_multi_ff;
   assign rsp_chan.debounced_level   = out_level_ff;
   assign rsp_chan.click_count       = out_count_ff;

   // long and multi events are exclusive on one item
   a_pulse_excl: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_long_ff && out_multi_ff))
      else $error("long and multi press on the same item");

   // an event always leaves the click count cleared
   a_event_clears: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && (out_long_ff || out_multi_ff) |-> out_count_ff == '0)
      else $error("click count not cleared by event");

   // a reported long press leaves the press marked as done
   a_long_held: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_long_ff |-> long_done_ff)
      else $error("long press reported without the press marked done");

endmodule
